// ===== rtl/schit_pkg.sv =====
package schit_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned RadiusBits = CoordBits - 1;
  localparam int unsigned TolBits = 8;
  localparam logic [TolBits-1:0] TolReset = 8'd3;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_END   = 2'd1,
    CAUSE_CLOSE = 2'd2
  } cause_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] seg_start_x;
    logic signed [CoordBits-1:0] seg_start_y;
    logic signed [CoordBits-1:0] seg_end_x;
    logic signed [CoordBits-1:0] seg_end_y;
    logic signed [CoordBits-1:0] centre_x;
    logic signed [CoordBits-1:0] centre_y;
    logic [RadiusBits-1:0]       radius;
  } item_t;

  typedef struct packed {
    logic   hit;
    cause_e cause;
  } result_t;

endpackage

// ===== rtl/schit_mul.sv =====
module schit_mul #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16
) (
  input  logic                     clk_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  // operands split into a zero-extended low half and a signed high half
  localparam int unsigned AL = (AW + 1) / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned BL = (BW + 1) / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned PW = AW + BW;

  logic signed [AL:0]      al;
  logic signed [AH-1:0]    ah;
  logic signed [BL:0]      bl;
  logic signed [BH-1:0]    bh;
  logic signed [AL+BL+1:0] ll_q;
  logic signed [AL+BH:0]   lh_q;
  logic signed [AH+BL:0]   hl_q;
  logic signed [AH+BH-1:0] hh_q;
  logic signed [PW-1:0]    p_q;

  assign al = $signed({1'b0, a_i[AL-1:0]});
  assign ah = $signed(a_i[AW-1:AL]);
  assign bl = $signed({1'b0, b_i[BL-1:0]});
  assign bh = $signed(b_i[BW-1:BL]);

  // first register: partial products
  always_ff @(posedge clk_i) begin
    ll_q <= al * bl;
    lh_q <= al * bh;
    hl_q <= ah * bl;
    hh_q <= ah * bh;
  end

  // second register: weighted sum; the full product fits PW bits, so wrap is harmless
  always_ff @(posedge clk_i) begin
    p_q <= PW'(ll_q) + (PW'(lh_q) <<< BL) + (PW'(hl_q) <<< AL)
         + (PW'(hh_q) <<< (AL + BL));
  end

  assign p_o = p_q;

endmodule

// ===== rtl/segment_circle_hit_test_unit.sv =====
// Segment / circle hit test, fully pipelined.
//
// Input: one transaction is taken at a rising edge with start high and
// busy low. busy is always low, so a new test can enter every cycle.
// item_i carries both segment end points, the circle center and the radius,
// all fixed point with 8 fraction bits.
// Output: each test yields exactly one result on result_o, shown for one
// cycle with done_o high. Results leave in
// the order the tests came in. The receiver cannot stall, so there is no
// backpressure anywhere in the pipe; throughput is one test per cycle.
// Pipeline: one difference stage, two multiplier ranks that each register
// partial products, then their sum, a sum stage and a select stage between
// the ranks, and the result register.
// Config: cfg_we_i writes on_segment_tolerance (reset value 3). Each test
// samples the tolerance at its start edge.
// Reset: rst_ni clears all stage valid bits and loads the tolerance.
module segment_circle_hit_test_unit
  import schit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  item_t               item_i,
  input  logic                cfg_we_i,
  input  logic [TolBits-1:0]  cfg_wdata_i,
  output logic                done_o,
  output result_t             result_o
);

  localparam int unsigned DW = CoordBits + 1;   // coordinate difference
  localparam int unsigned PW = 2 * DW;          // product of differences
  localparam int unsigned SW = PW + 1;          // sum of two products
  localparam int unsigned RW = 2 * (RadiusBits + 1);
  localparam int unsigned TW = 2 * (TolBits + 1);

  logic [TolBits-1:0] tol_q;
  logic               accept;
  logic               v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
    end else begin
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  // ---- stage 1: differences -------------------------------------------
  // d = end - start, w = center - start, v = center - end
  logic signed [DW-1:0]           dx_q, dy_q, wx_q, wy_q, vx_q, vy_q;
  logic signed [RadiusBits:0]     r_q;
  logic signed [TolBits:0]        t_q;

  always_ff @(posedge clk_i) begin
    dx_q <= DW'(item_i.seg_end_x) - DW'(item_i.seg_start_x);
    dy_q <= DW'(item_i.seg_end_y) - DW'(item_i.seg_start_y);
    wx_q <= DW'(item_i.centre_x) - DW'(item_i.seg_start_x);
    wy_q <= DW'(item_i.centre_y) - DW'(item_i.seg_start_y);
    vx_q <= DW'(item_i.centre_x) - DW'(item_i.seg_end_x);
    vy_q <= DW'(item_i.centre_y) - DW'(item_i.seg_end_y);
    r_q  <= {1'b0, item_i.radius};
    t_q  <= {1'b0, tol_q};
  end

  // ---- stages 2-3: first multiplier rank ------------------------------
  logic signed [PW-1:0] wxwx, wywy, vxvx, vyvy, dxdx, dydy;
  logic signed [PW-1:0] wxdx, wydy, wxdy, wydx;
  logic signed [RW-1:0] r2;
  logic signed [TW-1:0] t2;

  schit_mul #(.AW(DW), .BW(DW)) u_wxwx (.clk_i, .a_i(wx_q), .b_i(wx_q), .p_o(wxwx));
  schit_mul #(.AW(DW), .BW(DW)) u_wywy (.clk_i, .a_i(wy_q), .b_i(wy_q), .p_o(wywy));
  schit_mul #(.AW(DW), .BW(DW)) u_vxvx (.clk_i, .a_i(vx_q), .b_i(vx_q), .p_o(vxvx));
  schit_mul #(.AW(DW), .BW(DW)) u_vyvy (.clk_i, .a_i(vy_q), .b_i(vy_q), .p_o(vyvy));
  schit_mul #(.AW(DW), .BW(DW)) u_dxdx (.clk_i, .a_i(dx_q), .b_i(dx_q), .p_o(dxdx));
  schit_mul #(.AW(DW), .BW(DW)) u_dydy (.clk_i, .a_i(dy_q), .b_i(dy_q), .p_o(dydy));
  schit_mul #(.AW(DW), .BW(DW)) u_wxdx (.clk_i, .a_i(wx_q), .b_i(dx_q), .p_o(wxdx));
  schit_mul #(.AW(DW), .BW(DW)) u_wydy (.clk_i, .a_i(wy_q), .b_i(dy_q), .p_o(wydy));
  schit_mul #(.AW(DW), .BW(DW)) u_wxdy (.clk_i, .a_i(wx_q), .b_i(dy_q), .p_o(wxdy));
  schit_mul #(.AW(DW), .BW(DW)) u_wydx (.clk_i, .a_i(wy_q), .b_i(dx_q), .p_o(wydx));
  schit_mul #(.AW(RadiusBits + 1), .BW(RadiusBits + 1)) u_r2 (
    .clk_i, .a_i(r_q), .b_i(r_q), .p_o(r2));
  schit_mul #(.AW(TolBits + 1), .BW(TolBits + 1)) u_t2 (
    .clk_i, .a_i(t_q), .b_i(t_q), .p_o(t2));

  // ---- stage 4: sums and end point test -------------------------------
  logic signed [SW-1:0] e1, e2, len2_d, dot_d, cr_d;
  logic                 end_d;
  logic signed [SW-1:0] len2_3_q, dot_3_q, cr_3_q;
  logic signed [RW-1:0] r2_3_q;
  logic signed [TW-1:0] t2_3_q;
  logic                 end_3_q;

  always_comb begin
    e1     = SW'(wxwx) + SW'(wywy);
    e2     = SW'(vxvx) + SW'(vyvy);
    len2_d = SW'(dxdx) + SW'(dydy);
    dot_d  = SW'(wxdx) + SW'(wydy);
    cr_d   = SW'(wxdy) - SW'(wydx);
    // boundary counts as inside
    end_d  = (e1 <= r2) || (e2 <= r2);
  end

  always_ff @(posedge clk_i) begin
    len2_3_q <= len2_d;
    dot_3_q  <= dot_d;
    cr_3_q   <= cr_d;
    r2_3_q   <= r2;
    t2_3_q   <= t2;
    end_3_q  <= end_d;
  end

  // ---- stage 5: overshoot past the segment ends, |cross| --------------
  logic signed [SW-1:0] ov_d, cra_d;
  logic signed [SW-1:0] ov_4_q, cra_4_q, len2_4_q;
  logic signed [RW-1:0] r2_4_q;
  logic signed [TW-1:0] t2_4_q;
  logic                 end_4_q, lnz_4_q;

  always_comb begin
    if (dot_3_q < 0) begin
      ov_d = -dot_3_q;
    end else if (dot_3_q > len2_3_q) begin
      ov_d = dot_3_q - len2_3_q;
    end else begin
      ov_d = '0;
    end
    cra_d = (cr_3_q < 0) ? -cr_3_q : cr_3_q;
  end

  always_ff @(posedge clk_i) begin
    ov_4_q   <= ov_d;
    cra_4_q  <= cra_d;
    len2_4_q <= len2_3_q;
    r2_4_q   <= r2_3_q;
    t2_4_q   <= t2_3_q;
    end_4_q  <= end_3_q;
    lnz_4_q  <= (len2_3_q != '0);
  end

  // ---- stages 6-7: second multiplier rank -----------------------------
  // on segment:  (2*ov)^2     <= tol^2 * |d|^2
  // close:       (w x d)^2    <= r^2   * |d|^2
  localparam int unsigned OW = SW + 1;
  logic signed [OW-1:0]       ov2;
  logic signed [2*OW-1:0]     ovsq;
  logic signed [SW+TW-1:0]    lt;
  logic signed [2*SW-1:0]     crsq;
  logic signed [SW+RW-1:0]    lr;
  logic                       end_5_q, lnz_5_q, end_6_q, lnz_6_q;

  assign ov2 = {ov_4_q, 1'b0};

  schit_mul #(.AW(OW), .BW(OW)) u_ovsq (.clk_i, .a_i(ov2), .b_i(ov2), .p_o(ovsq));
  schit_mul #(.AW(SW), .BW(TW)) u_lt (.clk_i, .a_i(len2_4_q), .b_i(t2_4_q), .p_o(lt));
  schit_mul #(.AW(SW), .BW(SW)) u_crsq (.clk_i, .a_i(cra_4_q), .b_i(cra_4_q), .p_o(crsq));
  schit_mul #(.AW(SW), .BW(RW)) u_lr (.clk_i, .a_i(len2_4_q), .b_i(r2_4_q), .p_o(lr));

  always_ff @(posedge clk_i) begin
    end_5_q <= end_4_q;
    lnz_5_q <= lnz_4_q;
    end_6_q <= end_5_q;
    lnz_6_q <= lnz_5_q;
  end

  // ---- stage 8: final compares and result register --------------------
  logic    on_seg, close_in;
  result_t res_d, res_q;

  always_comb begin
    on_seg   = (ovsq <= lt);
    close_in = (crsq <= lr);
    res_d    = '{hit: 1'b0, cause: CAUSE_NONE};
    if (end_6_q) begin
      res_d = '{hit: 1'b1, cause: CAUSE_END};
    end else if (lnz_6_q && on_seg && close_in) begin
      res_d = '{hit: 1'b1, cause: CAUSE_CLOSE};
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = v8_q;
  assign result_o = res_q;

  // ---- assertions ------------------------------------------------------
  a_hit_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.hit == (result_o.cause != CAUSE_NONE)))
    else $error("hit and cause disagree");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##8 done_o)
    else $error("result missing eight cycles after start");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v7_q))
    else $error("result without a test in flight");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import schit_pkg::*;

  localparam int PipeDrain = 10;   // pipe is eight stages deep; a bit of margin

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  item_t               item_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [TolBits-1:0]  cfg_wdata_i = '0;
  logic                done_o;
  result_t             result_o;

  // golden copy of the tolerance register
  logic [TolBits-1:0]  tol_shadow = TolReset;
  result_t             pending_hits[$];
  bit                  mismatch_seen = 1'b0;
  bit                  gaps_on = 1'b1;

  segment_circle_hit_test_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always #2 clk_i = ~clk_i;

  // Exact integer version of the hit test. Widths are generous enough that
  // no intermediate can overflow, so no early rejection is needed.
  function automatic result_t predict_hit(item_t it, logic [TolBits-1:0] tol);
    logic signed [127:0] sx, sy, ex, ey, cx, cy, rad, tl;
    logic signed [127:0] dx, dy, wx, wy, r2, e1, e2, len2, dot, ov, cr;
    result_t res;
    bit on_seg;
    sx = it.seg_start_x;
    sy = it.seg_start_y;
    ex = it.seg_end_x;
    ey = it.seg_end_y;
    cx = it.centre_x;
    cy = it.centre_y;
    rad = $signed({105'b0, it.radius});
    tl = $signed({120'b0, tol});
    res.hit = 1'b0;
    res.cause = CAUSE_NONE;
    dx = ex - sx;
    dy = ey - sy;
    wx = cx - sx;
    wy = cy - sy;
    r2 = rad * rad;
    e1 = wx * wx + wy * wy;
    e2 = (cx - ex) * (cx - ex) + (cy - ey) * (cy - ey);
    if (e1 <= r2 || e2 <= r2) begin
      res.hit = 1'b1;
      res.cause = CAUSE_END;
    end else begin
      len2 = dx * dx + dy * dy;
      // zero-length segment with both ends outside: never a hit
      if (len2 != 0) begin
        dot = wx * dx + wy * dy;
        ov = 0;
        if (dot < 0) begin
          ov = -dot;
        end else if (dot > len2) begin
          ov = dot - len2;
        end
        // (d1 + d2) - length = 2*ov/|d|, squared against the tolerance
        on_seg = ((2 * ov) * (2 * ov)) <= (tl * tl * len2);
        if (on_seg) begin
          cr = wx * dy - wy * dx;
          if (cr < 0) begin
            cr = -cr;
          end
          if (cr * cr <= len2 * r2) begin
            res.hit = 1'b1;
            res.cause = CAUSE_CLOSE;
          end
        end
      end
    end
    return res;
  endfunction

  // One transaction on the start/busy handshake. Start stays high across
  // back-to-back items; an idle burst lowers it first.
  task automatic send_test(item_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_hits = {pending_hits, predict_hit(it, tol_shadow)};
  endtask

  task automatic drain_pipe();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk_i);
    repeat (PipeDrain) @(negedge clk_i);
  endtask

  task automatic write_tolerance(logic [TolBits-1:0] val);
    drain_pipe();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tol_shadow = val;
  endtask

  function automatic item_t make_item(int sx, int sy, int ex, int ey,
                                      int cx, int cy, int rad);
    item_t it;
    it.seg_start_x = sx[CoordBits-1:0];
    it.seg_start_y = sy[CoordBits-1:0];
    it.seg_end_x = ex[CoordBits-1:0];
    it.seg_end_y = ey[CoordBits-1:0];
    it.centre_x = cx[CoordBits-1:0];
    it.centre_y = cy[CoordBits-1:0];
    it.radius = rad[RadiusBits-1:0];
    return it;
  endfunction

  // Local scene: points and radius within one random scale around a base,
  // so the on-segment and closest-point checks get real exercise.
  function automatic item_t make_scene();
    int scale, bx, by;
    scale = 1 << $urandom_range(1, 21);
    bx = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    by = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    return make_item(bx + $signed($urandom_range(0, 2 * scale)) - scale,
                     by + $signed($urandom_range(0, 2 * scale)) - scale,
                     bx + $signed($urandom_range(0, 2 * scale)) - scale,
                     by + $signed($urandom_range(0, 2 * scale)) - scale,
                     bx, by, $urandom_range(0, scale / 2));
  endfunction

  // End point inside, on the boundary, and just outside; also zero-length, tangent and crossing segments.
  task automatic test_end_points();
    send_test(make_item(0, 0, 5000, 0, 300, 400, 500));      // start on boundary
    send_test(make_item(5000, 0, 0, 0, 300, 400, 500));      // end on boundary
    send_test(make_item(0, 0, 0, 5000, 300, 400, 499));      // just outside
    send_test(make_item(-7, 9, -7, 9, -7, 9, 0));            // point on centre, r=0
    send_test(make_item(100, 100, 100, 100, 0, 0, 50));      // zero-length, no hit
    send_test(make_item(-2560, 256, 2560, 256, 0, 0, 256));  // tangent at middle
    send_test(make_item(-2560, 257, 2560, 257, 0, 0, 256));  // just misses
    send_test(make_item(-2560, -2560, 2560, 2560, 0, 0, 1)); // crosses centre
  endtask

  // Closest point just beyond an end, against the current tolerance.
  task automatic test_on_segment();
    for (int k = 1; k <= 4; k++) begin
      send_test(make_item(0, 0, 2560, 0, 2560 + k, 0, 0));
      send_test(make_item(0, 0, 2560, 0, -k, 0, 0));
    end
    send_test(make_item(0, 0, 2560, 0, 2700, 50, 60));
  endtask

  task automatic test_extremes();
    int lo, hi, rmax;
    lo = -(1 << 23);
    hi = (1 << 23) - 1;
    rmax = (1 << 23) - 1;
    send_test(make_item(lo, lo, hi, hi, hi, lo, 0));
    send_test(make_item(lo, hi, hi, lo, lo, lo, rmax));
    send_test(make_item(hi, hi, lo, lo, 0, 0, 0));
    send_test(make_item(lo, lo, lo, lo, hi, hi, rmax));
    send_test(make_item(hi, lo, lo, hi, 0, 0, 1));
  endtask

  task automatic test_random(int count);
    item_t it;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        it = make_item(int'($urandom), int'($urandom), int'($urandom),
                       int'($urandom), int'($urandom), int'($urandom),
                       int'($urandom));
      end else begin
        it = make_scene();
      end
      send_test(it);
    end
  endtask

  // Result checker: done_o cannot be held off, so every strobe counts.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b cause=%0d", $time,
                 result_o.hit, result_o.cause);
        mismatch_seen = 1'b1;
      end else begin
        if (result_o.hit !== pending_hits[0].hit) begin
          $display("%0t: hit expected %0b actual %0b", $time,
                   pending_hits[0].hit, result_o.hit);
          mismatch_seen = 1'b1;
        end
        if (result_o.cause !== pending_hits[0].cause) begin
          $display("%0t: cause expected %0d actual %0d", $time,
                   pending_hits[0].cause, result_o.cause);
          mismatch_seen = 1'b1;
        end
        void'(pending_hits.pop_front());
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // reset tolerance first
    test_end_points();
    test_on_segment();
    test_extremes();
    test_random(300);
    write_tolerance(8'd0);
    test_on_segment();
    test_random(250);
    write_tolerance(8'd255);
    test_on_segment();
    test_random(250);
    write_tolerance($urandom_range(1, 254));
    test_random(250);
    // last stretch streams back to back
    write_tolerance(TolReset);
    gaps_on = 1'b0;
    test_on_segment();
    test_random(200);
    drain_pipe();
    if (pending_hits.size() == 0 && !mismatch_seen) begin
      $display("segment_circle_hit_test_unit: match");
    end else begin
      $display("segment_circle_hit_test_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("segment_circle_hit_test_unit: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/schit_pkg.sv
rtl/schit_mul.sv
rtl/segment_circle_hit_test_unit.sv
test/tb_top.sv
